/* hdl/sha256_pkg.sv */
// SHA-256 package: round constants, initial hash values, controller state type
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       put_byte;    // write data byte at current position
    logic       put_pad;     // write pad byte (0x80 first, then zero)
    logic       put_len;     // write length words 14/15
    logic       start_round; // copy hash into working vars, clear round
    logic       do_round;    // run one round
    logic       fold;        // add working vars into hash
    logic       reinit;      // restore initial hash and clear count
    logic       mark_pad;    // remember 0x80 written
  } cmd_t;

  typedef struct packed {
    logic       round_last;  // round counter at 63
    logic [5:0] pos;         // block byte position
    logic       pad_done;    // 0x80 already written
  } status_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

/* hdl/sha256_datapath.sv */
// SHA-256 datapath: block buffer, message schedule window, working variables,
// hash state and byte counter. Depends on sha256_pkg.
`timescale 1ns / 1ps
module sha256_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  sha256_pkg::cmd_t     cmd,
  input  logic [7:0]           data_byte,
  input  logic [2:0]           emit_index,
  output sha256_pkg::status_t  status,
  output logic [31:0]          hash_word
);
  import sha256_pkg::*;

  logic [31:0] blk [16];   // block words, later the schedule window
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [60:0] count;
  logic [5:0]  round;
  logic        pad_done;

  logic [5:0]  pos;
  logic [7:0]  wr_byte;
  logic        wr_en;
  logic [63:0] bits;
  logic [31:0] s0, s1, w_new, t1, t2, ch, maj, sig0, sig1;

  assign bits = {count, 3'b000};
  assign wr_byte = cmd.put_pad ? (pad_done ? 8'h00 : PAD_BYTE) : data_byte;
  assign wr_en = cmd.put_byte | cmd.put_pad;

  always_comb begin
    s0 = {blk[1][6:0], blk[1][31:7]} ^ {blk[1][17:0], blk[1][31:18]} ^ (blk[1] >> 3);
    s1 = {blk[14][16:0], blk[14][31:17]} ^ {blk[14][18:0], blk[14][31:19]}
       ^ (blk[14] >> 10);
    w_new = s1 + blk[9] + s0 + blk[0];
    sig1 = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^ {v[4][24:0], v[4][31:25]};
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + sig1 + ch + ROUND_K[round] + blk[0];
    sig0 = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^ {v[0][21:0], v[0][31:22]};
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = sig0 + maj;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (pos[1:0] == 2'd0) begin
        blk[pos[5:2]] <= {wr_byte, 24'h0};
      end else begin
        blk[pos[5:2]] <= blk[pos[5:2]] | ({24'h0, wr_byte} << ({3'd0, 2'd3 - pos[1:0]} * 5'd8));
      end
    end else if (cmd.put_len) begin
      blk[14] <= bits[63:32];
      blk[15] <= bits[31:0];
    end else if (cmd.do_round) begin
      for (int i = 0; i < 15; i++) blk[i] <= blk[i + 1];
      blk[15] <= w_new;
    end
    if (cmd.start_round) begin
      for (int i = 0; i < 8; i++) v[i] <= h[i];
    end else if (cmd.do_round) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      for (int i = 0; i < 8; i++) h[i] <= INIT_H[i];
      count <= '0;
      pos <= '0;
      round <= '0;
      pad_done <= 1'b0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
      end
      // every data or pad byte write advances the block position; only data bytes add to the length
      if (wr_en) pos <= pos + 6'd1;
      if (cmd.put_byte) count <= count + 61'd1;
      if (cmd.start_round) round <= '0;
      else if (cmd.do_round) round <= round + 6'd1;
      if (cmd.mark_pad) pad_done <= 1'b1;
    end
  end

  assign status.round_last = (round == LAST_POS);
  assign status.pos = pos;
  assign status.pad_done = pad_done;
  assign hash_word = h[emit_index];

endmodule

/* hdl/sha256_ctrl.sv */
// SHA-256 controller: sequences load, rounds, padding and digest emission.
// Depends on sha256_pkg.
`timescale 1ns / 1ps
module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 has_byte,
  input  logic                 msg_end,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [2:0]           emit_index,
  input  sha256_pkg::status_t  status,
  output sha256_pkg::cmd_t     cmd
);
  import sha256_pkg::*;

  state_t state, state_next;
  logic   finishing, finishing_next;   // message end pending
  logic   len_block, len_block_next;   // current compression holds length
  logic [2:0] idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      finishing <= 1'b0;
      len_block <= 1'b0;
      emit_index <= '0;
    end else begin
      state <= state_next;
      finishing <= finishing_next;
      len_block <= len_block_next;
      emit_index <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    finishing_next = finishing;
    len_block_next = len_block;
    idx_next = emit_index;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.put_byte = has_byte;
          finishing_next = msg_end;
          if (has_byte && status.pos == LAST_POS) begin
            cmd.start_round = 1'b1;
            len_block_next = 1'b0;
            state_next = ST_ROUND;
          end else if (msg_end) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        cmd.do_round = 1'b1;
        if (status.round_last) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (len_block) begin
          idx_next = '0;
          state_next = ST_EMIT;
        end else if (finishing) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_LOAD;
        end
      end
      ST_PAD: begin
        // one byte per cycle until the length slot, wrapping via extra block
        if (status.pad_done && status.pos == LEN_POS) begin
          cmd.put_len = 1'b1;
          cmd.start_round = 1'b1;
          len_block_next = 1'b1;
          state_next = ST_ROUND;
        end else begin
          cmd.put_pad = 1'b1;
          cmd.mark_pad = 1'b1;
          if (status.pos == LAST_POS) begin
            cmd.start_round = 1'b1;
            len_block_next = 1'b0;
            state_next = ST_ROUND;
          end
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          idx_next = emit_index + 3'd1;
          if (emit_index == 3'd7) begin
            cmd.reinit = 1'b1;
            finishing_next = 1'b0;
            len_block_next = 1'b0;
            state_next = ST_LOAD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_out_outside_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_EMIT) else $error("output outside emit");
  a_round_to_fold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && status.round_last) |=> state == ST_FOLD)
    else $error("round count overrun");
  a_emit_starts_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FOLD && len_block) |=> emit_index == 3'd0)
    else $error("emit index not cleared");
`endif

endmodule

/* hdl/sha256_stream_hasher_core.sv */
// SHA-256 streaming hasher top level: joins controller and datapath.
// Depends on sha256_pkg, sha256_ctrl, sha256_datapath.
`timescale 1ns / 1ps
// One byte transfer per cycle while a block fills. When the 64th byte of a
// block lands, input stalls through the 64 rounds of the single shared
// round unit and the fold of the working variables into the hash.
// An end-of-message transfer writes the pad one byte per cycle up to the
// length slot (at most 56 pad bytes, then the length words; when fewer
// than 9 bytes remained, up to 8 more pad bytes and a second compression
// come first), compresses the length block, then presents the eight digest
// words, word 0 first, one per unstalled cycle. Hash state returns to the
// initial values after the last word is taken.
module sha256_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        msg_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_last
);
  import sha256_pkg::*;

  cmd_t       cmd;
  status_t    status;
  logic [2:0] emit_index;

  sha256_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .has_byte(has_byte), .msg_end(msg_end), .out_stall(out_stall),
    .out_valid(out_valid), .emit_index(emit_index), .status(status), .cmd(cmd)
  );

  sha256_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .data_byte(data_byte),
    .emit_index(emit_index), .status(status), .hash_word(digest_word)
  );

  // hold word position straight from the emit counter
  assign word_index = emit_index;
  assign digest_last = (emit_index == 3'd7);

endmodule
